// ----- hdl/sha256_stream_hasher_unit_defines.svh -----
// assertion macros for the sha-256 hasher checker
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// implication checked at every clock edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sha_pkg.sv -----
// ---------------------------------------------------------------------------
// sha_pkg
// types, constants and round functions shared by the sha-256 hasher
// ---------------------------------------------------------------------------
package sha_pkg;

   localparam int unsigned NumRounds = 64;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned PadLimit = 56;
   localparam logic [7:0] PadByte = 8'h80;

   typedef enum logic {
      CMD_ABSORB = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_PAD_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       buf_write;    // write one byte into the block buffer
      logic [5:0] buf_addr;
      logic [7:0] buf_data;
      logic       count_byte;   // advance byte total
      logic       work_load;    // copy chain into working vars
      logic       round_step;   // one round
      logic [5:0] round_idx;
      logic       chain_add;    // fold working vars into chain
      logic       emit_shift;   // rotate chain by one word for output
      logic       reinit;       // restore initial state
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [63:0] bit_len;
   } sts_type;

   localparam logic [31:0] InitChain [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      sig0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      sig1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

endpackage

// ----- hdl/sha_ctrl.sv -----
// ---------------------------------------------------------------------------
// sha_ctrl
// sequencer: byte intake, padding, round counting and digest output
// ---------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_last,
   output logic [2:0] rsp_index,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type  state_ff, state_in;
   logic [5:0] fill_ff, fill_in;     // bytes pending
   logic [5:0] cnt_ff, cnt_in;       // pad address / round / word index
   logic       final_ff, final_in;   // current block is the last one
   logic       spill_ff, spill_in;   // set when a finish needs a second block

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         final_ff <= final_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      final_in  = final_ff;
      ctl       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last  = (cnt_ff[2:0] == 3'd7);
      rsp_index = cnt_ff[2:0];
      ctl.round_idx = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.command == CMD_ABSORB) begin
                  ctl.buf_write  = 1'b1;
                  ctl.buf_addr   = fill_ff;
                  ctl.buf_data   = req_data.data_byte;
                  ctl.count_byte = 1'b1;
                  fill_in        = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     final_in = 1'b0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  ctl.buf_write = 1'b1;
                  ctl.buf_addr  = fill_ff;
                  ctl.buf_data  = PadByte;
                  cnt_in        = fill_ff + 6'd1;
                  final_in      = (fill_ff < 6'(PadLimit));
                  if (fill_ff == 6'd63) state_in = ST_LOAD;
                  else state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // zero fill; the final block stops at the length field
            ctl.buf_write = 1'b1;
            ctl.buf_addr  = cnt_ff;
            ctl.buf_data  = '0;
            if (final_ff && cnt_ff >= 6'(PadLimit)) begin
               ctl.buf_write = 1'b0;
               state_in = ST_PAD_LEN;
            end else begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) state_in = ST_LOAD;
            end
         end
         ST_PAD_LEN: begin
            ctl.buf_write = 1'b1;
            ctl.buf_addr  = cnt_ff;
            ctl.buf_data  = sts.bit_len[8'(6'd63 - cnt_ff) * 8 +: 8];
            cnt_in        = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            ctl.work_load = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            ctl.round_step = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            ctl.chain_add = 1'b1;
            fill_in = '0;
            cnt_in  = '0;
            if (spill_ff) begin
               // spill block of a finish: resume padding into the final block
               final_in = 1'b1;
               state_in = ST_PAD;
            end else if (final_ff) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               ctl.emit_shift = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  ctl.reinit = 1'b1;
                  cnt_in   = '0;
                  final_in = 1'b0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) spill_ff <= 1'b0;
      else spill_ff <= spill_in;
   end
   always_comb begin
      spill_in = spill_ff;
      if (state_ff == ST_IDLE && req_valid && req_data.command == CMD_FINISH)
         spill_in = (fill_ff >= 6'(PadLimit));
      else if (state_ff == ST_ADD) spill_in = 1'b0;
   end

endmodule

// ----- hdl/sha_dp.sv -----
// ---------------------------------------------------------------------------
// sha_dp
// message window doubling as block buffer, round unit and chaining words
// ---------------------------------------------------------------------------
module sha_dp import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   output logic [31:0] digest_word
);

   logic [31:0] w_ff [16];
   logic [31:0] chain_ff [8], chain_in [8];
   logic [31:0] v_ff [8];
   logic [63:0] total_ff, total_in;
   logic [31:0] w_cur, w_new, t1, t2;

   // schedule: a 16-word window, word i at slot 0
   assign w_new = w_ff[0] + sig0(w_ff[1]) + w_ff[9] + sig1(w_ff[14]);
   assign w_cur = w_ff[0];

   // bytes land big-endian in the window; rounds then shift it
   always_ff @(posedge clock) begin
      if (ctl.buf_write) begin
         w_ff[ctl.buf_addr[5:2]][{~ctl.buf_addr[1:0], 3'b000} +: 8] <= ctl.buf_data;
      end else if (ctl.round_step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[ctl.round_idx] + w_cur;
   assign t2 = bsig0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_ff @(posedge clock) begin
      if (ctl.work_load) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
      end else if (ctl.round_step) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i];
      total_in = total_ff;
      if (ctl.count_byte) total_in = total_ff + 64'd1;
      if (ctl.chain_add) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + v_ff[i];
      end
      if (ctl.emit_shift) begin
         for (int i = 0; i < 7; i++) chain_in[i] = chain_ff[i+1];
         chain_in[7] = chain_ff[0];
      end
      if (ctl.reinit) begin
         for (int i = 0; i < 8; i++) chain_in[i] = InitChain[i];
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= InitChain[i];
         total_ff <= '0;
      end else begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_in[i];
         total_ff <= total_in;
      end
   end

   assign sts.bit_len = {total_ff[60:0], 3'b000};
   assign digest_word = chain_ff[0];

endmodule

// ----- hdl/sha256_stream_hasher_unit.sv -----
// ---------------------------------------------------------------------------
// sha256_stream_hasher_unit
// byte-serial sha-256 hasher with eight-word digest output
// ---------------------------------------------------------------------------
// channel  direction  word
// req      in         command, data_byte
// rsp      out        digest_word, word_index, last
//
// an absorb writes one byte; the 64th byte of a block also starts a compression
// (load, 64 rounds on one round unit, chain add)
// a finish pads one byte a cycle to the block end, compresses once or twice,
// then shows eight digest words, one per cycle when rsp_stall is low
// reset is synchronous and restores the initial chain; req stalls while busy
module sha256_stream_hasher_unit import sha_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   ctl_type     ctl;
   sts_type     sts;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;

   // sequencer
   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_last  (last),
      .rsp_index (word_index),
      .sts       (sts),
      .ctl       (ctl)
   );

   // buffer, schedule, rounds, chain
   sha_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .digest_word (digest_word)
   );

   assign rsp_data = '{digest_word: digest_word, word_index: word_index, last: last};

endmodule

// ----- hdl/sha_checker.sv -----
// ---------------------------------------------------------------------------
// sha_checker
// port-level checks of the hasher
// ---------------------------------------------------------------------------
`include "sha256_stream_hasher_unit_defines.svh"
module sha_checker import sha_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input req_type req_data,
   input logic    req_stall,
   input logic    rsp_valid,
   input rsp_type rsp_data,
   input logic    rsp_stall
);

   `SHA_ASSERT_IMPL(a_last_idx, clock, reset, rsp_valid, rsp_data.last == (rsp_data.word_index == 3'd7), "last flag mismatch")
   `SHA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, req_stall, "input taken while output shown")
   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled word changed")
   `SHA_ASSERT_NEXT(a_idx_step, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last, rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1, "word index skipped")

endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (.*);
